[rtl/core/rps_pkg.sv]
// ----------------------------------------------------------------------------
// rps_pkg
// Shared constants and types for the permutation shuffler.
// ----------------------------------------------------------------------------
package rps_pkg;

   // Field widths
   localparam int WORD_W    = 32;
   localparam int COUNT_W   = 7;
   localparam int ELEM_W    = 6;
   localparam int POS_W     = 6;
   localparam int BIT_CNT_W = $clog2(WORD_W);

   // Element count after reset
   localparam logic [COUNT_W-1:0] ELEMENT_COUNT_RST = 7'd64;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MOD    = 5'b00010,
      ST_RD_TOP = 5'b00100,
      ST_RD_IDX = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

endpackage

[rtl/core/random_permutation_shuffler.sv]
// ----------------------------------------------------------------------------
// random_permutation_shuffler
// Fisher-Yates shuffle engine driven by externally supplied random words.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction carries a 32-bit random word. Each accepted word
//            yields exactly one rsp_* transaction: the element placed at the
//            current position, the position itself (counting down from the
//            effective count minus one) and a flag on the final position.
//   csr_*  : writes element_count; clamped to 1..MAX_ELEMENTS. A write
//            restarts the run (table back to identity). Taken only when idle;
//            while csr_valid is high the req_* side is stalled.
//   Steps  : a transaction runs from acceptance through the bit-serial remainder
//            (one dividend bit per cycle), two table reads through the single
//            RAM read port and a write-back, which also loads the result into
//            the output register. The next word is taken only once the
//            sequencer is back in idle after that write-back.
//   Stall  : the result sits in an output register; a new word is accepted
//            while it waits, but the write-back of that word holds until the
//            output register has been taken.
//   Reset  : synchronous, active high. element_count returns to 64, the table
//            reads as identity at once (per-entry valid bits are cleared).
// ----------------------------------------------------------------------------
module random_permutation_shuffler
   import rps_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic                clock,
   input  logic                reset,
   // random word input
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [WORD_W-1:0]   req_random_word,
   // result output
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ELEM_W-1:0]   rsp_element,
   output logic [POS_W-1:0]    rsp_position,
   output logic                rsp_last_of_run,
   // configuration write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [COUNT_W-1:0]  csr_element_count
);

   // Counts are COUNT_W bits wide, so no run reaches an entry past that range
   localparam int TBL_N = (MAX_ELEMENTS < (1 << COUNT_W)) ? MAX_ELEMENTS
                                                           : (1 << COUNT_W);
   localparam int AW = $clog2(TBL_N);
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int RST_EFF = (MAX_ELEMENTS < 64) ? MAX_ELEMENTS : 64;

   // Clamp a configured count to 1..MAX_ELEMENTS
   function automatic logic [CW-1:0] eff_count(input logic [COUNT_W-1:0] n);
      logic [EW-1:0] n_ext;
      n_ext = EW'(n);
      if (n_ext == '0) begin
         eff_count = CW'(1);
      end else if (n_ext > EW'(MAX_ELEMENTS)) begin
         eff_count = CW'(MAX_ELEMENTS);
      end else begin
         eff_count = CW'(n_ext);
      end
   endfunction

   state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [CW-1:0]             remain_ff, remain_in;
   logic [TBL_N-1:0]          valid_ff, valid_in;
   logic [WORD_W-1:0]         word_ff, word_in;
   logic [CW-1:0]             rem_ff, rem_in;
   logic [BIT_CNT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [AW-1:0]             top_val_ff, top_val_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0]         elem_ff, elem_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic                      last_ff, last_in;

   logic                      req_fire;
   logic                      csr_fire;
   logic                      out_free;
   logic [CW-1:0]             top_full;
   logic [AW-1:0]             top_addr;
   logic [AW-1:0]             idx_addr;
   logic [CW:0]               trial;
   logic [CW:0]               divisor;
   logic [AW-1:0]             rd_addr;
   logic [AW-1:0]             rd_data;
   logic                      wr_en;
   logic [AW-1:0]             elem_val;

   // Handshakes; a pending register write takes precedence over a word
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_fire  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Addresses of the current step
   assign top_full = remain_ff - CW'(1);
   assign top_addr = AW'(top_full);
   assign idx_addr = AW'(rem_ff);
   assign rd_addr  = (state_ff == ST_RD_TOP) ? top_addr : idx_addr;

   // Restoring remainder step, one dividend bit per cycle
   assign trial   = {rem_ff, word_ff[WORD_W-1]};
   assign divisor = {1'b0, remain_ff};

   // Entry not written this run reads as identity
   assign elem_val = valid_ff[idx_addr] ? rd_data : idx_addr;

   assign wr_en = (state_ff == ST_DONE) && out_free;

   // Permutation table
   rps_ram #(
      .WIDTH(AW),
      .DEPTH(TBL_N)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(idx_addr),
      .wr_data(top_val_ff),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      valid_in     = valid_ff;
      word_in      = word_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      top_val_in   = top_val_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      elem_in      = elem_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_fire) begin
               count_in  = csr_element_count;
               remain_in = eff_count(csr_element_count);
               valid_in  = '0;
            end else if (req_fire) begin
               word_in    = req_random_word;
               rem_in     = '0;
               bit_cnt_in = '0;
               state_in   = ST_MOD;
            end
         end
         ST_MOD: begin
            if (trial >= divisor) begin
               rem_in = CW'(trial - divisor);
            end else begin
               rem_in = CW'(trial);
            end
            word_in    = word_ff << 1;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(WORD_W - 1)) begin
               state_in = ST_RD_TOP;
            end
         end
         ST_RD_TOP: begin
            state_in = ST_RD_IDX;
         end
         ST_RD_IDX: begin
            top_val_in = valid_ff[top_addr] ? rd_data : top_addr;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               elem_in      = ELEM_W'(elem_val);
               pos_in       = POS_W'(top_full);
               last_in      = (top_full == '0);
               if (top_full == '0) begin
                  valid_in  = '0;
                  remain_in = eff_count(count_ff);
               end else begin
                  valid_in[idx_addr] = 1'b1;
                  remain_in          = top_full;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= ELEMENT_COUNT_RST;
         remain_ff    <= CW'(RST_EFF);
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      top_val_ff <= top_val_in;
      elem_ff    <= elem_in;
      pos_ff     <= pos_in;
      last_ff    <= last_in;
   end

   // Outputs
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_element     = elem_ff;
   assign rsp_position    = pos_ff;
   assign rsp_last_of_run = last_ff;

endmodule

[rtl/core/rps_ram.sv]
// ----------------------------------------------------------------------------
// rps_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[bench/tb_random_permutation_shuffler.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_random_permutation_shuffler
// Self-checking bench for the Fisher-Yates shuffle engine. A directed table
// covers reset state, clamped counts and aborted runs; random phases follow
// with mostly complete permutations at varied counts. Every result is checked
// against typed expectations or an in-bench shuffle model, under random sender gaps and rsp stalls.
// ----------------------------------------------------------------------------
module tb_random_permutation_shuffler
   import rps_pkg::*;
();

   localparam int MAX_EL      = 64;
   localparam int LATENCY     = 40;
   localparam int RANDOM_WORDS = 550;
   localparam int DIR_N       = 26;

   typedef enum bit {ROW_WORD, ROW_CFG} row_kind_type;

   typedef struct {
      logic [ELEM_W-1:0] element;
      logic [POS_W-1:0]  position;
      logic              last;
   } pick_type;

   typedef struct {
      row_kind_type kind;
      logic [31:0]  value;
      bit           typed;
      int           el;
      int           pos;
      bit           last;
   } dir_row_type;

   // DUT signals
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [WORD_W-1:0]   req_random_word = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ELEM_W-1:0]   rsp_element;
   logic [POS_W-1:0]    rsp_position;
   logic                rsp_last_of_run;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [COUNT_W-1:0]  csr_element_count = '0;

   // Shuffle model state and pending picks
   logic [ELEM_W-1:0]   shuffle_table [MAX_EL];
   int                  left_count;
   logic [COUNT_W-1:0]  count_reg;
   pick_type            pending_picks [$];

   int err_cnt     = 0;
   int sent_cnt    = 0;
   int checked_cnt = 0;
   int perm_cnt    = 0;
   int cfg_cnt     = 0;
   int burst_left  = 0;
   int stall_hold  = 0;

   // Directed stimulus: typed expectations where obvious, model elsewhere
   dir_row_type dir_rows [DIR_N] = '{
      '{ROW_WORD, 32'h0000_0000, 1,  0, 63, 0},  // first pick after reset
      '{ROW_WORD, 32'hFFFF_FFFF, 0,  0,  0, 0},
      '{ROW_CFG,  32'd1,         0,  0,  0, 0},
      '{ROW_WORD, 32'hFFFF_FFFF, 1,  0,  0, 1},  // single element run
      '{ROW_WORD, 32'h1234_5678, 1,  0,  0, 1},
      '{ROW_CFG,  32'd0,         0,  0,  0, 0},  // zero count acts as one
      '{ROW_WORD, 32'hFFFF_FFFF, 1,  0,  0, 1},
      '{ROW_WORD, 32'hAAAA_AAAA, 1,  0,  0, 1},
      '{ROW_CFG,  32'd127,       0,  0,  0, 0},  // clamps to max
      '{ROW_WORD, 32'd63,        1, 63, 63, 0},
      '{ROW_WORD, 32'h5555_5555, 0,  0,  0, 0},
      '{ROW_CFG,  32'd65,        0,  0,  0, 0},
      '{ROW_WORD, 32'hFFFF_FFFF, 0,  0,  0, 0},
      '{ROW_CFG,  32'd2,         0,  0,  0, 0},
      '{ROW_WORD, 32'd1,         1,  1,  1, 0},
      '{ROW_WORD, 32'd0,         1,  0,  0, 1},
      '{ROW_WORD, 32'd0,         1,  0,  1, 0},  // fresh run after last
      '{ROW_CFG,  32'd3,         0,  0,  0, 0},
      '{ROW_WORD, 32'd2,         1,  2,  2, 0},
      '{ROW_CFG,  32'd3,         0,  0,  0, 0},  // abort mid-run
      '{ROW_WORD, 32'd2,         1,  2,  2, 0},
      '{ROW_WORD, 32'h8000_0000, 0,  0,  0, 0},
      '{ROW_WORD, 32'd7,         0,  0,  0, 0},
      '{ROW_CFG,  32'd64,        0,  0,  0, 0},
      '{ROW_WORD, 32'd64,        1,  0, 63, 0},
      '{ROW_WORD, 32'hFFFF_FFFF, 0,  0,  0, 0}
   };

   random_permutation_shuffler #(
      .MAX_ELEMENTS (MAX_EL)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_random_word   (req_random_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_element       (rsp_element),
      .rsp_position      (rsp_position),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_element_count (csr_element_count)
   );

   // Clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Count after clamping to 1..MAX_EL
   function automatic int eff_count(logic [COUNT_W-1:0] c);
      if (c == 0)
         return 1;
      if (c > MAX_EL)
         return MAX_EL;
      return int'(c);
   endfunction

   function automatic void restart_table();
      for (int i = 0; i < MAX_EL; i++)
         shuffle_table[i] = ELEM_W'(i);
      left_count = eff_count(count_reg);
   endfunction

   // One Fisher-Yates step: pick, swap into the top slot, shrink
   function automatic pick_type shuffle_pick(logic [WORD_W-1:0] w);
      pick_type          res;
      int                r;
      int                idx;
      int                top;
      logic [ELEM_W-1:0] chosen;
      r = left_count;
      if (r == 0 || r > MAX_EL)
         r = eff_count(count_reg);
      idx = int'(w % 32'(r));
      top = r - 1;
      chosen = shuffle_table[idx];
      shuffle_table[idx] = shuffle_table[top];
      shuffle_table[top] = chosen;
      left_count = top;
      res.element  = chosen;
      res.position = POS_W'(top);
      res.last     = (top == 0);
      if (top == 0)
         restart_table();
      return res;
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 5))
         0:       return 32'($urandom_range(0, 200));
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h1 << $urandom_range(0, 31);
         3:       return ~(32'h1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      err_cnt++;
   endtask

   // Send one word in bursts with random gaps; queue its expected pick
   task automatic send_word(logic [WORD_W-1:0] w, bit typed, pick_type typed_res);
      pick_type res;
      int       gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid       <= 1'b1;
      req_random_word <= w;
      do @(posedge clock); while (req_stall);
      burst_left--;
      sent_cnt++;
      res = shuffle_pick(w);
      if (typed)
         res = typed_res;
      pending_picks.push_back(res);
   endtask

   // Drain all outstanding picks, then let the engine settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_picks.size() != 0)
         @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_count(logic [COUNT_W-1:0] c);
      csr_valid         <= 1'b1;
      csr_element_count <= c;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      count_reg = c;
      restart_table();
      cfg_cnt++;
   endtask

   // Receiver stall pattern: long holds, quiet stretches and random chatter
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         case ($urandom_range(0, 5))
            0: begin
               rsp_stall  <= 1'b1;
               stall_hold <= $urandom_range(1, 40);
            end
            1: begin
               rsp_stall  <= 1'b0;
               stall_hold <= $urandom_range(200, 400);
            end
            default: begin
               rsp_stall  <= 1'($urandom_range(0, 1));
               stall_hold <= $urandom_range(0, 15);
            end
         endcase
      end
   end

   // Result checker against the oldest pending pick
   always @(posedge clock) begin
      pick_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_picks.size() == 0) begin
            report_mismatch("results outstanding", 1, 0);
         end else begin
            want = pending_picks.pop_front();
            if (rsp_element !== want.element)
               report_mismatch("element", rsp_element, want.element);
            if (rsp_position !== want.position)
               report_mismatch("position", rsp_position, want.position);
            if (rsp_last_of_run !== want.last)
               report_mismatch("last_of_run", rsp_last_of_run, want.last);
            checked_cnt++;
            if (rsp_last_of_run)
               perm_cnt++;
         end
      end
   end

   // Stimulus
   initial begin
      pick_type           typed_res;
      logic [COUNT_W-1:0] c;
      int                 eff;
      int                 n;
      int                 total;
      count_reg = ELEMENT_COUNT_RST;
      restart_table();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      total = 0;
      for (int i = 0; i < DIR_N; i++) begin
         if (dir_rows[i].kind == ROW_CFG) begin
            wait_idle();
            write_count(dir_rows[i].value[COUNT_W-1:0]);
         end else begin
            typed_res.element  = ELEM_W'(dir_rows[i].el);
            typed_res.position = POS_W'(dir_rows[i].pos);
            typed_res.last     = dir_rows[i].last;
            send_word(dir_rows[i].value, dir_rows[i].typed, typed_res);
         end
      end

      // random phases, mostly whole permutations, some cut short
      total = sent_cnt + RANDOM_WORDS;
      while (sent_cnt < total) begin
         case ($urandom_range(0, 7))
            0:       c = 7'd1;
            1:       c = 7'd64;
            2:       c = 7'd0;
            3:       c = 7'd127;
            4:       c = 7'd2;
            5:       c = 7'($urandom_range(65, 127));
            default: c = 7'($urandom_range(1, 64));
         endcase
         wait_idle();
         write_count(c);
         eff = eff_count(c);
         if ($urandom_range(0, 4) == 0)
            n = $urandom_range(1, 2 * eff);
         else
            n = eff * ((eff <= 16) ? $urandom_range(1, 3) : 1);
         if (n > total - sent_cnt)
            n = total - sent_cnt;
         repeat (n) send_word(pick_word(), 0, typed_res);
      end

      wait_idle();
      $display("%0d words shuffled, %0d results checked", sent_cnt, checked_cnt);
      $display("%0d permutations completed over %0d count writes", perm_cnt, cfg_cnt);
      if (err_cnt == 0 && pending_picks.size() == 0)
         $display("random_permutation_shuffler test passed");
      else
         $display("random_permutation_shuffler test failed");
      $finish;
   end

   // Watchdog
   initial begin
      #2ms;
      $display("random_permutation_shuffler test failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/rps_pkg.sv
rtl/core/rps_ram.sv
rtl/core/random_permutation_shuffler.sv
bench/tb_random_permutation_shuffler.sv
